>>> design/wfg_pkg.sv
// ----------------------------------------------------------------------------
// wfg_pkg
// Shared types, constants and the sine table of the waveform generator.
// ----------------------------------------------------------------------------
`default_nettype none

package wfg_pkg;

    // Register map: register index i sits at byte address 4*i.
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam logic REG_WAVE_MODE  = 1'b0;
    localparam logic REG_STEP_DELAY = 1'b1;

    localparam int SINE_POINTS = 32;
    localparam int ROM_SIZE    = 32;
    localparam int ROM_IDX_W   = $clog2(ROM_SIZE);
    localparam int SQUARE_HALF = 17;
    localparam int SQUARE_LEN  = 2 * SQUARE_HALF;

    // The position counter serves both the sine table and the square period.
    localparam int SINE_IDX_W = $clog2(SINE_POINTS);
    localparam int SQ_IDX_W   = $clog2(SQUARE_LEN);
    localparam int STEP_W     = (SINE_IDX_W > SQ_IDX_W) ? SINE_IDX_W : SQ_IDX_W;

    localparam int TICK_W  = 12;
    localparam int LEVEL_W = 8;
    localparam int DELAY_W = 8;

    typedef enum logic [1:0] {
        MODE_SINE     = 2'd0,
        MODE_TRIANGLE = 2'd1,
        MODE_SAWTOOTH = 2'd2,
        MODE_SQUARE   = 2'd3
    } wave_mode_t;

    typedef struct packed {
        logic [TICK_W-1:0]  tick_count;
        logic [STEP_W-1:0]  step_index;
        logic [LEVEL_W-1:0] level;
        logic               rising;
    } wave_state_t;

    localparam wave_state_t STATE_CLEAR = '{
        tick_count: '0,
        step_index: '0,
        level:      '0,
        rising:     1'b1
    };

    typedef logic [LEVEL_W-1:0] rom_t [ROM_SIZE];

    localparam rom_t SINE_ROM = '{
        8'd128, 8'd152, 8'd176, 8'd198, 8'd217, 8'd233, 8'd245, 8'd252,
        8'd255, 8'd252, 8'd245, 8'd233, 8'd217, 8'd198, 8'd176, 8'd152,
        8'd128, 8'd103, 8'd79,  8'd57,  8'd38,  8'd22,  8'd10,  8'd3,
        8'd1,   8'd3,   8'd10,  8'd22,  8'd38,  8'd57,  8'd79,  8'd103
    };

    // Table entry for a sine position when the point count differs from the
    // table size.
    function automatic logic [LEVEL_W-1:0] sine_level(input logic [STEP_W-1:0] idx);
        int scaled;
        scaled = (int'(idx) * ROM_SIZE) / SINE_POINTS;
        return SINE_ROM[scaled[ROM_IDX_W-1:0]];
    endfunction

endpackage

`default_nettype wire

>>> design/wfg_step.sv
// ----------------------------------------------------------------------------
// wfg_step
// Next-state and result logic for one tick of the waveform generator.
// ----------------------------------------------------------------------------
`default_nettype none

module wfg_step (
    input  wfg_pkg::wave_state_t                 state,
    input  wfg_pkg::wave_mode_t                  wave_mode,
    input  logic [wfg_pkg::DELAY_W-1:0]          step_delay,
    input  logic                                 run,
    output wfg_pkg::wave_state_t                 state_next,
    output logic [wfg_pkg::LEVEL_W-1:0]          sample_next,
    output logic                                 new_step_next
);

    logic [wfg_pkg::DELAY_W:0]    delay_ext;
    logic [wfg_pkg::TICK_W-1:0]   step_len;
    logic [wfg_pkg::TICK_W:0]     tick_inc;
    logic [wfg_pkg::STEP_W-1:0]   sine_idx;
    logic [wfg_pkg::STEP_W-1:0]   sq_idx;
    logic [wfg_pkg::STEP_W-1:0]   sine_idx_inc;
    logic [wfg_pkg::STEP_W-1:0]   sq_idx_inc;
    logic [wfg_pkg::LEVEL_W-1:0]  tri_level;
    wfg_pkg::wave_state_t         stepped;

    // A delay of zero stands for 256; sine and sawtooth hold ten times longer.
    assign delay_ext = {(step_delay == '0), step_delay};

    always_comb
    begin
        if (wave_mode == wfg_pkg::MODE_SINE || wave_mode == wfg_pkg::MODE_SAWTOOTH)
        begin
            step_len = wfg_pkg::TICK_W'({delay_ext, 3'b000})
                     + wfg_pkg::TICK_W'({delay_ext, 1'b0});
        end
        else
        begin
            step_len = wfg_pkg::TICK_W'(delay_ext);
        end
    end

    // The position is always below twice either sequence length.
    assign sine_idx = (state.step_index >= wfg_pkg::STEP_W'(wfg_pkg::SINE_POINTS))
                    ? state.step_index - wfg_pkg::STEP_W'(wfg_pkg::SINE_POINTS)
                    : state.step_index;
    assign sq_idx   = (state.step_index >= wfg_pkg::STEP_W'(wfg_pkg::SQUARE_LEN))
                    ? state.step_index - wfg_pkg::STEP_W'(wfg_pkg::SQUARE_LEN)
                    : state.step_index;

    assign sine_idx_inc = (sine_idx == wfg_pkg::STEP_W'(wfg_pkg::SINE_POINTS - 1))
                        ? '0 : sine_idx + 1'b1;
    assign sq_idx_inc   = (sq_idx == wfg_pkg::STEP_W'(wfg_pkg::SQUARE_LEN - 1))
                        ? '0 : sq_idx + 1'b1;

    assign tri_level = state.rising ? state.level + 1'b1 : state.level - 1'b1;

    always_comb
    begin
        stepped = state;
        unique case (wave_mode)
            wfg_pkg::MODE_SINE:
            begin
                stepped.level      = wfg_pkg::sine_level(sine_idx);
                stepped.step_index = sine_idx_inc;
            end
            wfg_pkg::MODE_TRIANGLE:
            begin
                stepped.level = tri_level;
                if (state.rising && tri_level == '1)
                begin
                    stepped.rising = 1'b0;
                end
                else if (!state.rising && tri_level == '0)
                begin
                    stepped.rising = 1'b1;
                end
            end
            wfg_pkg::MODE_SAWTOOTH:
            begin
                stepped.level = state.level + wfg_pkg::LEVEL_W'(4);
            end
            wfg_pkg::MODE_SQUARE:
            begin
                stepped.level = (sq_idx < wfg_pkg::STEP_W'(wfg_pkg::SQUARE_HALF))
                              ? '0 : '1;
                stepped.step_index = sq_idx_inc;
            end
        endcase
    end

    assign tick_inc = {1'b0, state.tick_count} + 1'b1;

    always_comb
    begin
        if (!run)
        begin
            state_next    = wfg_pkg::STATE_CLEAR;
            sample_next   = '0;
            new_step_next = 1'b0;
        end
        else
        begin
            state_next = (state.tick_count == '0) ? stepped : state;
            // A shortened delay ends the step as soon as the count reaches it.
            state_next.tick_count = (tick_inc >= {1'b0, step_len})
                                  ? '0 : tick_inc[wfg_pkg::TICK_W-1:0];
            sample_next   = state_next.level;
            new_step_next = (state.tick_count == '0);
        end
    end

endmodule

`default_nettype wire

>>> design/waveform_generator_unit.sv
// ----------------------------------------------------------------------------
// waveform_generator_unit
// Sine, triangle, sawtooth and square generator producing one 8-bit level per
// tick request, with mode and step delay set through an APB-style port.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------
//  in      | request   | in_valid / in_stall  | run
//  out     | result    | out_valid / out_stall| sample, new_step
//  cfg     | APB write | psel/penable/pready  | paddr, pwdata, prdata
//
//  A request is taken each cycle unless stalled; its result is out next cycle.
//  The waveform state updates in a single pass between the state registers
//  and the result register, so the next request never waits on the last.
//  in_stall is raised only while a held result is stalled at the output.
//  Reset clears the waveform state, selects sine and sets the delay to one.
// ----------------------------------------------------------------------------
`default_nettype none

module waveform_generator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          run,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [wfg_pkg::LEVEL_W-1:0]   sample,
    output logic                          new_step,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wfg_pkg::ADDR_W-1:0]    paddr,
    input  logic [wfg_pkg::DATA_W-1:0]    pwdata,
    output logic [wfg_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    wfg_pkg::wave_mode_t               wave_mode_reg;
    logic [wfg_pkg::DELAY_W-1:0]       step_delay_reg;
    wfg_pkg::wave_state_t              state_reg;
    wfg_pkg::wave_state_t              state_next;
    logic                              out_valid_reg;
    logic [wfg_pkg::LEVEL_W-1:0]       sample_reg;
    logic [wfg_pkg::LEVEL_W-1:0]       sample_next;
    logic                              new_step_reg;
    logic                              new_step_next;
    logic                              in_accept;
    logic                              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_mode_reg  <= wfg_pkg::MODE_SINE;
            step_delay_reg <= wfg_pkg::DELAY_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                wfg_pkg::REG_WAVE_MODE:  wave_mode_reg  <= wfg_pkg::wave_mode_t'(pwdata[1:0]);
                wfg_pkg::REG_STEP_DELAY: step_delay_reg <= pwdata[wfg_pkg::DELAY_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            wfg_pkg::REG_WAVE_MODE:  prdata = wfg_pkg::DATA_W'(wave_mode_reg);
            wfg_pkg::REG_STEP_DELAY: prdata = wfg_pkg::DATA_W'(step_delay_reg);
        endcase
    end

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    wfg_step u_step (
        .state         (state_reg),
        .wave_mode     (wave_mode_reg),
        .step_delay    (step_delay_reg),
        .run           (run),
        .state_next    (state_next),
        .sample_next   (sample_next),
        .new_step_next (new_step_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wfg_pkg::STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                state_reg <= state_next;
            end
            if (!in_stall)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg   <= sample_next;
            new_step_reg <= new_step_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign new_step  = new_step_reg;

endmodule

`default_nettype wire

>>> design/wfg_checker.sv
// ----------------------------------------------------------------------------
// wfg_checker
// Port-level checks on the waveform generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wfg_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          run,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [wfg_pkg::LEVEL_W-1:0]   sample,
    input  logic                          new_step
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample) && $stable(new_step))
        else $error("stalled result changed");

    // Every accepted request yields a result in the next cycle.
    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted request produced no result");

    // A stop request gives a zero level and no step mark.
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !run |=> sample == '0 && !new_step)
        else $error("stop request gave a nonzero result");

    // Input is only held back by a stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // A run request taken right after a stop request always starts a new step.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !run ##1 in_valid && !in_stall && run
        |=> new_step)
        else $error("first tick after a stop did not start a step");

endmodule

bind waveform_generator_unit wfg_checker u_wfg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .run       (run),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample),
    .new_step  (new_step)
);

`default_nettype wire

>>> tb/tb_waveform_generator_unit.sv
// ----------------------------------------------------------------------------
// tb_waveform_generator_unit
// Self-checking testbench for the waveform generator. A clocked driver sends
// run requests from a queue and a clocked monitor takes the results.
// Every accepted request is run through a local model of the four waveforms,
// and each result is checked against the oldest expected sample. Mode and
// step delay are reprogrammed over the APB port between phases. The phases
// use different idle and stall rates, and one phase holds the output off long
// enough to back the generator up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_waveform_generator_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;

    typedef struct {
        logic [wfg_pkg::LEVEL_W-1:0] sample;
        logic                        new_step;
    } wave_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic                         run = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [wfg_pkg::LEVEL_W-1:0]  sample;
    logic                         new_step;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [wfg_pkg::ADDR_W-1:0]   paddr = '0;
    logic [wfg_pkg::DATA_W-1:0]   pwdata = '0;
    logic [wfg_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    // Run requests waiting to be driven and samples waiting to come out.
    logic         pending_runs[$];
    wave_result_t expected_samples[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;

    // Local copy of the configuration and of the generator state.
    wfg_pkg::wave_mode_t          cfg_mode  = wfg_pkg::MODE_SINE;
    logic [wfg_pkg::DELAY_W-1:0]  cfg_delay = 8'd1;
    int                           gen_ticks  = 0;
    int                           gen_pos    = 0;
    logic [wfg_pkg::LEVEL_W-1:0]  gen_level  = '0;
    logic                         gen_rising = 1'b1;

    waveform_generator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .run       (run),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample),
        .new_step  (new_step),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t ns: %s", $time, msg);
    endtask

    // Advances the generator by one tick and returns the sample it drives.
    function automatic wave_result_t advance_wave(input logic run_bit);
        wave_result_t r;
        int           hold;
        r.sample   = '0;
        r.new_step = 1'b0;
        if (!run_bit)
        begin
            gen_ticks  = 0;
            gen_pos    = 0;
            gen_level  = '0;
            gen_rising = 1'b1;
            return r;
        end
        if (gen_ticks == 0)
        begin
            case (cfg_mode)
                wfg_pkg::MODE_SINE:
                begin
                    gen_pos   = gen_pos % wfg_pkg::SINE_POINTS;
                    gen_level = wfg_pkg::SINE_ROM[(gen_pos * wfg_pkg::ROM_SIZE)
                                                  / wfg_pkg::SINE_POINTS];
                    gen_pos   = (gen_pos + 1) % wfg_pkg::SINE_POINTS;
                end
                wfg_pkg::MODE_TRIANGLE:
                begin
                    if (gen_rising)
                    begin
                        gen_level = gen_level + 8'd1;
                        if (gen_level == 8'hFF)
                            gen_rising = 1'b0;
                    end
                    else
                    begin
                        gen_level = gen_level - 8'd1;
                        if (gen_level == 8'h00)
                            gen_rising = 1'b1;
                    end
                end
                wfg_pkg::MODE_SAWTOOTH:
                    gen_level = gen_level + 8'd4;
                default:
                begin
                    gen_pos   = gen_pos % wfg_pkg::SQUARE_LEN;
                    gen_level = (gen_pos < wfg_pkg::SQUARE_HALF) ? 8'h00 : 8'hFF;
                    gen_pos   = (gen_pos + 1) % wfg_pkg::SQUARE_LEN;
                end
            endcase
            r.new_step = 1'b1;
        end
        // A delay of zero stands for 256 ticks.
        hold = (cfg_delay == 0) ? 256 : int'(cfg_delay);
        if (cfg_mode == wfg_pkg::MODE_SINE || cfg_mode == wfg_pkg::MODE_SAWTOOTH)
            hold *= 10;
        gen_ticks++;
        if (gen_ticks >= hold)
            gen_ticks = 0;
        r.sample = gen_level;
        return r;
    endfunction

    // Request driver: a request is held until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            run      <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_samples.push_back(advance_wave(run));
            if (!in_valid || !in_stall)
            begin
                if (pending_runs.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    in_valid <= 1'b1;
                    run      <= pending_runs.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long output hold, counted on its own.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left   <= 0;
            hold_served <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
        end
    end

    // Result monitor and output stall.
    always @(posedge clk or negedge rst_n)
    begin
        wave_result_t exp_r;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    report_mismatch($sformatf("result with nothing expected: sample %0d",
                                              sample));
                end
                else
                begin
                    exp_r = expected_samples.pop_front();
                    if (sample !== exp_r.sample)
                        report_mismatch($sformatf("sample %0d, expected %0d",
                                                  sample, exp_r.sample));
                    if (new_step !== exp_r.new_step)
                        report_mismatch($sformatf("new_step %0b, expected %0b",
                                                  new_step, exp_r.new_step));
                end
            end
            if (hold_left > 0 || hold_served != hold_requests)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(99) < sink_stall_pct);
        end
    end

    // Ends the run when neither channel has moved for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no handshake for %0d cycles", $time, quiet_cycles);
                $display("waveform_generator_unit: mismatch");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic reg_idx, input logic [wfg_pkg::DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == wfg_pkg::REG_WAVE_MODE)
            cfg_mode = wfg_pkg::wave_mode_t'(value[1:0]);
        else
            cfg_delay = value[wfg_pkg::DELAY_W-1:0];
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_runs.size() > 0 || in_valid || expected_samples.size() > 0)
            @(negedge clk);
    endtask

    task automatic queue_runs(input int count, input int stop_pct);
        for (int i = 0; i < count; i++)
            pending_runs.push_back($urandom_range(99) >= stop_pct);
    endtask

    // One random phase. The generator state is kept across the register
    // writes, so a phase that starts without a stop continues the old step.
    task automatic run_phase(input wfg_pkg::wave_mode_t mode,
                             input logic [wfg_pkg::DELAY_W-1:0] delay,
                             input int src_pct, input int sink_pct,
                             input int stop_pct, input int count, input bit hold);
        apb_write(wfg_pkg::REG_WAVE_MODE, wfg_pkg::DATA_W'(mode));
        apb_write(wfg_pkg::REG_STEP_DELAY, wfg_pkg::DATA_W'(delay));
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        queue_runs(count, stop_pct);
        if (hold)
            hold_requests++;
        wait_drained();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, a stop, a sine step boundary, a stop in
        // the middle of a step, then triangle and sawtooth with a delay of one and square with long delays.
        pending_runs.push_back(1'b0);
        repeat (12) pending_runs.push_back(1'b1);
        pending_runs.push_back(1'b0);
        repeat (2) pending_runs.push_back(1'b1);
        wait_drained();
        apb_write(wfg_pkg::REG_WAVE_MODE, wfg_pkg::DATA_W'(wfg_pkg::MODE_TRIANGLE));
        repeat (3) pending_runs.push_back(1'b1);
        wait_drained();
        apb_write(wfg_pkg::REG_WAVE_MODE, wfg_pkg::DATA_W'(wfg_pkg::MODE_SAWTOOTH));
        repeat (2) pending_runs.push_back(1'b1);
        wait_drained();
        apb_write(wfg_pkg::REG_WAVE_MODE, wfg_pkg::DATA_W'(wfg_pkg::MODE_SQUARE));
        apb_write(wfg_pkg::REG_STEP_DELAY, wfg_pkg::DATA_W'(0));
        repeat (2) pending_runs.push_back(1'b1);
        wait_drained();
        apb_write(wfg_pkg::REG_STEP_DELAY, wfg_pkg::DATA_W'(8'd255));
        pending_runs.push_back(1'b0);
        pending_runs.push_back(1'b1);
        wait_drained();

        // Random: long clean runs take the triangle over its top and the
        // sine through a full period; shorter phases add stops.
        run_phase(wfg_pkg::MODE_TRIANGLE, 8'd1,   0,  0,  0, 290, 1'b0);
        run_phase(wfg_pkg::MODE_SINE,     8'd1,  53,  0,  0, 340, 1'b0);
        run_phase(wfg_pkg::MODE_SAWTOOTH, 8'd1,   0, 53,  3,  60, 1'b0);
        run_phase(wfg_pkg::MODE_SQUARE,   8'd1,  12, 12,  3,  80, 1'b0);
        run_phase(wfg_pkg::MODE_TRIANGLE, 8'd255, 0,  0,  2,  50, 1'b1);
        run_phase(wfg_pkg::MODE_SQUARE,   8'd0,  12, 12,  2,  40, 1'b0);

        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("waveform_generator_unit: match");
        else
            $display("waveform_generator_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
